>>> hw/rtl/wpe_pkg.sv
package wpe_pkg;

  localparam int unsigned LengthWidthDefault = 32;
  localparam int unsigned QueueDepthDefault  = 4;

  localparam logic [31:0] IdFmt      = 32'h2074_6D66;
  localparam logic [31:0] IdData     = 32'h6174_6164;
  localparam logic [31:0] MinFile    = 32'd44;
  localparam logic [31:0] MinFmt     = 32'd16;
  localparam logic [31:0] FirstChunk = 32'd12;
  localparam logic [31:0] HeaderLen  = 32'd8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SMALL = 3'd1,
    ST_NOT_WAVE  = 3'd2,
    ST_FMT_SMALL = 3'd3,
    ST_NO_DATA   = 3'd4,
    ST_NOT_PCM16 = 3'd5
  } status_e;

  typedef struct packed {
    logic        pay_valid;
    logic [7:0]  pay_byte;
    logic        rep_valid;
    status_e     status;
    logic [31:0] rate;
    logic [15:0] channels;
  } entry_t;

  function automatic logic [7:0] riff_tag(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h52;
      2'd1: r = 8'h49;
      2'd2: r = 8'h46;
      default: r = 8'h46;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] wave_tag(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h57;
      2'd1: r = 8'h41;
      2'd2: r = 8'h56;
      default: r = 8'h45;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/wpe_parser.sv
module wpe_parser
  import wpe_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = LengthWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  file_byte_i,
  input  logic [31:0] file_length_i,
  input  logic        end_of_file_i,
  output logic        push_o,
  output entry_t      entry_o
);

  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_CHDR  = 3'd1,
    PH_FMT   = 3'd2,
    PH_SKIP  = 3'd3,
    PH_DATA  = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  logic [31:0] pos_q, pos_d;
  phase_e      phase_q, phase_d;
  logic [63:0] hs_q, hs_d;
  logic [31:0] rem_q, rem_d;
  logic        pad_q, pad_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  status_e     err_q, err_d;

  logic [LENGTH_WIDTH-1:0] len;
  logic [63:0]             hs_next;
  logic [31:0]             size_next;
  logic [31:0]             rem_dec;
  logic [31:0]             off;
  logic                    emit_pay;
  status_e                 st;

  assign len       = file_length_i[LENGTH_WIDTH-1:0];
  assign hs_next   = {file_byte_i, hs_q[63:8]};
  assign size_next = hs_next[63:32];
  assign rem_dec   = rem_q - 32'd1;
  assign off       = hs_q[63:32] - rem_q;

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    hs_d     = hs_q;
    rem_d    = rem_q;
    pad_d    = pad_q;
    fmt_d    = fmt_q;
    ch_d     = ch_q;
    rate_d   = rate_q;
    bits_d   = bits_q;
    err_d    = err_q;
    emit_pay = 1'b0;
    st       = ST_OK;

    case (phase_q)
      PH_MAGIC: begin
        if (pos_q == 32'd0 && 32'(len) < MinFile) begin
          err_d   = ST_TOO_SMALL;
          phase_d = PH_DONE;
        end else if (pos_q < 32'd4 && file_byte_i != riff_tag(pos_q[1:0])) begin
          err_d   = ST_NOT_WAVE;
          phase_d = PH_DONE;
        end else if (pos_q >= 32'd8 && pos_q < FirstChunk &&
                     file_byte_i != wave_tag(pos_q[1:0])) begin
          err_d   = ST_NOT_WAVE;
          phase_d = PH_DONE;
        end else if (pos_q >= FirstChunk - 32'd1) begin
          phase_d = PH_CHDR;
          rem_d   = HeaderLen;
          pad_d   = 1'b0;
        end
      end
      PH_CHDR: begin
        if (pad_q) begin
          pad_d = 1'b0;
        end else if (rem_q == HeaderLen &&
                     {1'b0, pos_q} + 33'd8 > 33'(len)) begin
          err_d   = ST_NO_DATA;
          phase_d = PH_DONE;
        end else begin
          hs_d  = hs_next;
          rem_d = (rem_q != 32'd0) ? rem_dec : rem_q;
          if (rem_q <= 32'd1) begin
            if (34'(pos_q) + 34'd1 + 34'(size_next) > 34'(len)) begin
              err_d   = ST_NO_DATA;
              phase_d = PH_DONE;
            end else if (hs_next[31:0] == IdFmt) begin
              if (size_next < MinFmt) begin
                err_d   = ST_FMT_SMALL;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_FMT;
                rem_d   = size_next;
              end
            end else if (hs_next[31:0] == IdData) begin
              if (size_next == 32'd0) begin
                err_d   = ST_NO_DATA;
                phase_d = PH_DONE;
              end else if (fmt_q != 16'd1 || bits_q != 16'd16) begin
                err_d   = ST_NOT_PCM16;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_DATA;
                rem_d   = size_next;
              end
            end else if (size_next == 32'd0) begin
              phase_d = PH_CHDR;
              rem_d   = HeaderLen;
            end else begin
              phase_d = PH_SKIP;
              rem_d   = size_next;
            end
          end
        end
      end
      PH_FMT, PH_SKIP: begin
        if (phase_q == PH_FMT) begin
          if (off == 32'd0) begin
            fmt_d[7:0] = file_byte_i;
          end else if (off == 32'd1) begin
            fmt_d[15:8] = file_byte_i;
          end else if (off == 32'd2) begin
            ch_d[7:0] = file_byte_i;
          end else if (off == 32'd3) begin
            ch_d[15:8] = file_byte_i;
          end else if (off >= 32'd4 && off <= 32'd7) begin
            rate_d[{off[1:0], 3'b000} +: 8] = file_byte_i;
          end else if (off == 32'd14) begin
            bits_d[7:0] = file_byte_i;
          end else if (off == 32'd15) begin
            bits_d[15:8] = file_byte_i;
          end
        end
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          pad_d   = hs_q[32];
          phase_d = PH_CHDR;
          rem_d   = HeaderLen;
        end
      end
      PH_DATA: begin
        emit_pay = 1'b1;
        rem_d    = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_d = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (pos_q != 32'hFFFF_FFFF) begin
      pos_d = pos_q + 32'd1;
    end

    st = err_d;
    if (err_d == ST_OK && phase_d != PH_DONE) begin
      st = (phase_d == PH_MAGIC) ? ST_TOO_SMALL : ST_NO_DATA;
    end

    entry_o.pay_valid = emit_pay;
    entry_o.pay_byte  = file_byte_i;
    entry_o.rep_valid = end_of_file_i;
    entry_o.status    = st;
    entry_o.rate      = (st == ST_OK) ? rate_d : 32'd0;
    entry_o.channels  = (st == ST_OK) ? ch_d : 16'd0;

    if (end_of_file_i) begin
      pos_d   = 32'd0;
      phase_d = PH_MAGIC;
      hs_d    = 64'd0;
      rem_d   = 32'd0;
      pad_d   = 1'b0;
      fmt_d   = 16'd0;
      ch_d    = 16'd0;
      rate_d  = 32'd0;
      bits_d  = 16'd0;
      err_d   = ST_OK;
    end
  end

  assign push_o = accept_i && (emit_pay || end_of_file_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 32'd0;
      phase_q <= PH_MAGIC;
      hs_q    <= 64'd0;
      rem_q   <= 32'd0;
      pad_q   <= 1'b0;
      fmt_q   <= 16'd0;
      ch_q    <= 16'd0;
      rate_q  <= 32'd0;
      bits_q  <= 16'd0;
      err_q   <= ST_OK;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      hs_q    <= hs_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
      fmt_q   <= fmt_d;
      ch_q    <= ch_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      err_q   <= err_d;
    end
  end

endmodule

>>> hw/rtl/wpe_queue.sv
module wpe_queue
  import wpe_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o,
  output logic   full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == Full);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> hw/rtl/wpe_emitter.sv
module wpe_emitter
  import wpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic [31:0] sample_rate_o,
  output logic [15:0] channel_count_o,
  output logic        is_last_o
);

  logic        out_valid_q, out_valid_d;
  logic        half_q, half_d;
  logic        load;
  logic        send_pay;
  logic        kind_q;
  logic [7:0]  byte_q;
  status_e     status_q;
  logic [31:0] rate_q;
  logic [15:0] ch_q;

  assign load     = !q_empty_i && (!out_valid_q || pop_i);
  assign send_pay = head_i.pay_valid && !half_q;

  always_comb begin
    out_valid_d = out_valid_q;
    half_d      = half_q;
    q_pop_o     = 1'b0;
    if (out_valid_q && pop_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (send_pay && head_i.rep_valid) begin
        half_d = 1'b1;
      end else begin
        half_d  = 1'b0;
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      half_q      <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (send_pay) begin
        kind_q   <= 1'b0;
        byte_q   <= head_i.pay_byte;
        status_q <= ST_OK;
        rate_q   <= 32'd0;
        ch_q     <= 16'd0;
      end else begin
        kind_q   <= 1'b1;
        byte_q   <= 8'd0;
        status_q <= head_i.status;
        rate_q   <= head_i.rate;
        ch_q     <= head_i.channels;
      end
    end
  end

  assign empty_o         = !out_valid_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = byte_q;
  assign status_o        = status_q;
  assign sample_rate_o   = rate_q;
  assign channel_count_o = ch_q;
  assign is_last_o       = kind_q;

  a_half_has_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> (!q_empty_i && head_i.rep_valid && head_i.pay_valid))
    else $error("Split word lost its report half.");

  a_half_after_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && send_pay && head_i.rep_valid) |=> (half_q && out_valid_q && !kind_q))
    else $error("Payload of a combined word was not followed by its report.");

  a_error_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q && status_q != ST_OK) |-> (rate_q == 32'd0 && ch_q == 16'd0))
    else $error("Failed report carries format values.");

endmodule

>>> hw/rtl/wav_pcm16_payload_extractor.sv
// WAV PCM16 payload extractor.
// The input side is a queue: a file word (one byte, the file length and an
// end-of-file mark) is taken on a rising edge with push high and full low.
// The result side is a queue too: while empty is low the oldest result word
// is on the result ports, and it is taken on a rising edge with pop high.
// Each data chunk byte of a PCM16 file yields one payload word, and the final
// byte of a file yields a status report after any payload word of that byte.
// A byte is taken every cycle while full is low; its first result passes the
// queue and then the output register to reach the ports, and a report that
// follows a payload word of the same byte appears once that word is popped.
// With full low and pop high, throughput is one input word and one result word
// per cycle, set by the one-byte-per-cycle chunk parser.
// A short queue between the parser and the output stage absorbs stalls; when
// the receiver holds off pop the queue fills and full goes high.
// Reset clears the parser, the queue and the output stage, so no result is
// pending after reset. After each final byte the parser returns to its reset
// state for the next file.
module wav_pcm16_payload_extractor
  import wpe_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = LengthWidthDefault,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  file_byte_i,
  input  logic [31:0] file_length_i,
  input  logic        end_of_file_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic [31:0] sample_rate_o,
  output logic [15:0] channel_count_o,
  output logic        is_last_o
);

  logic   accept;
  logic   q_push;
  logic   q_pop;
  logic   q_empty;
  entry_t q_entry;
  entry_t q_head;

  assign accept = push && !full;

  wpe_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .file_byte_i  (file_byte_i),
    .file_length_i(file_length_i),
    .end_of_file_i(end_of_file_i),
    .push_o       (q_push),
    .entry_o      (q_entry)
  );

  wpe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .pop_i  (q_pop),
    .head_o (q_head),
    .empty_o(q_empty),
    .full_o (full)
  );

  wpe_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .status_o       (status_o),
    .sample_rate_o  (sample_rate_o),
    .channel_count_o(channel_count_o),
    .is_last_o      (is_last_o)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import wpe_pkg::*;

  localparam int ITEM_GOAL = 1700;
  localparam int DIR_N = 24;
  localparam int WATCHDOG = 2000;
  localparam int SETTLE = 20;
  localparam int QUIET_TAIL = 150;
  localparam int MAX_REPORTS = 50;
  localparam logic [31:0] RIFF_WORD = 32'h4646_4952;
  localparam logic [31:0] WAVE_WORD = 32'h4556_4157;
  localparam logic [15:0] PCM_TAG = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;

  typedef enum logic [2:0] {
    WALK_MAGIC, WALK_HEADER, WALK_FMT, WALK_SKIP, WALK_DATA, WALK_DONE
  } walk_e;

  typedef struct packed {
    logic [7:0]  b;
    logic [31:0] len;
    logic        eof;
    logic        typed;
    logic [2:0]  st;
  } file_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pay;
    status_e     st;
    logic [31:0] rate;
    logic [15:0] chan;
    logic        last;
  } out_word_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  file_byte_i = 8'h00;
  logic [31:0] file_length_i = 32'd0;
  logic        end_of_file_i = 1'b0;
  logic        full;
  logic        empty;
  logic        kind_o;
  logic [7:0]  payload_byte_o;
  logic [2:0]  status_o;
  logic [31:0] sample_rate_o;
  logic [15:0] channel_count_o;
  logic        is_last_o;

  wav_pcm16_payload_extractor uut (
    .clk_i, .rst_ni, .push, .full, .file_byte_i, .file_length_i, .end_of_file_i,
    .empty, .pop, .kind_o, .payload_byte_o, .status_o, .sample_rate_o,
    .channel_count_o, .is_last_o
  );

  // Short files: size and tag errors, an early end inside the tags, a file cut
  // right after the WAVE tag, and bytes ignored after an error.
  file_word_t dir_rows [DIR_N] = '{
    {8'h00, 32'd0, 1'b1, 1'b1, ST_TOO_SMALL},
    {8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_NOT_WAVE},
    {8'h52, 32'd43, 1'b1, 1'b1, ST_TOO_SMALL},
    {8'h52, 32'd1000, 1'b0, 1'b0, ST_OK},
    {8'h49, 32'd1000, 1'b0, 1'b0, ST_OK},
    {8'h46, 32'd1000, 1'b0, 1'b0, ST_OK},
    {8'h58, 32'd1000, 1'b1, 1'b1, ST_NOT_WAVE},
    {8'h52, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h49, 32'd44, 1'b1, 1'b1, ST_TOO_SMALL},
    {8'h52, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h49, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h46, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h46, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'hFF, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h00, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'hA5, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h5A, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h57, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h41, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h56, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h45, 32'd44, 1'b1, 1'b1, ST_NO_DATA},
    {8'h51, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'h00, 32'd44, 1'b0, 1'b0, ST_OK},
    {8'hFF, 32'd44, 1'b1, 1'b1, ST_NOT_WAVE}
  };

  file_word_t wav_stream[$];
  out_word_t  extracted_words[$];
  logic [7:0] file_bytes[$];

  walk_e       walk;
  logic [31:0] pos;
  logic [31:0] remain;
  logic [63:0] hdr;
  logic        pad;
  logic [15:0] fmt_code;
  logic [15:0] chans;
  logic [31:0] rate_seen;
  logic [15:0] bits;
  status_e     verdict;

  int taken_bytes = 0;
  int bad_words = 0;
  int quiet_cycles = 0;
  int quiet_from = 0;
  int shown = -1;
  int push_hold = 0;
  int pop_hold = 0;
  int idle_odds = 0;
  int odds_timer = 0;
  logic moved;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_parser();
    walk = WALK_MAGIC;
    pos = '0;
    remain = '0;
    hdr = '0;
    pad = 1'b0;
    fmt_code = '0;
    chans = '0;
    rate_seen = '0;
    bits = '0;
    verdict = ST_OK;
  endtask

  task automatic end_walk(input status_e code);
    verdict = code;
    walk = WALK_DONE;
  endtask

  task automatic close_body();
    pad = hdr[32];
    walk = WALK_HEADER;
    remain = HeaderLen;
  endtask

  function automatic out_word_t report_word(input status_e s, input logic [31:0] r,
                                            input logic [15:0] c);
    out_word_t w;
    w.kind = 1'b1;
    w.pay = 8'h00;
    w.st = s;
    w.rate = (s == ST_OK) ? r : 32'd0;
    w.chan = (s == ST_OK) ? c : 16'd0;
    w.last = 1'b1;
    return w;
  endfunction

  task automatic parse_wav_byte(input logic [7:0] b, input logic [31:0] len, input logic eof);
    logic [33:0] p;
    logic [33:0] l;
    logic [31:0] id;
    logic [31:0] sz;
    logic [31:0] off;
    status_e     s;
    out_word_t   w;
    p = {2'b00, pos};
    l = {2'b00, len};
    case (walk)
      WALK_MAGIC: begin
        if (pos == 0 && len < MinFile) end_walk(ST_TOO_SMALL);
        else if (pos < 4 && b != RIFF_WORD[8*pos[1:0] +: 8]) end_walk(ST_NOT_WAVE);
        else if (pos >= 8 && pos < FirstChunk && b != WAVE_WORD[8*pos[1:0] +: 8])
          end_walk(ST_NOT_WAVE);
        else if (p + 1 >= FirstChunk) begin
          walk = WALK_HEADER;
          remain = HeaderLen;
          pad = 1'b0;
        end
      end
      WALK_HEADER: begin
        if (pad) begin
          pad = 1'b0;
        end else if (remain == HeaderLen && p + 8 > l) begin
          end_walk(ST_NO_DATA);
        end else begin
          hdr = {b, hdr[63:8]};
          if (remain != 0) remain = remain - 1;
          if (remain == 0) begin
            id = hdr[31:0];
            sz = hdr[63:32];
            if (p + 34'd1 + {2'b00, sz} > l) begin
              end_walk(ST_NO_DATA);
            end else if (id == IdFmt) begin
              if (sz < MinFmt) end_walk(ST_FMT_SMALL);
              else begin
                walk = WALK_FMT;
                remain = sz;
              end
            end else if (id == IdData) begin
              if (sz == 0) end_walk(ST_NO_DATA);
              else if (fmt_code != PCM_TAG || bits != PCM_BITS) end_walk(ST_NOT_PCM16);
              else begin
                walk = WALK_DATA;
                remain = sz;
              end
            end else if (sz == 0) begin
              remain = HeaderLen;
            end else begin
              walk = WALK_SKIP;
              remain = sz;
            end
          end
        end
      end
      WALK_FMT: begin
        off = hdr[63:32] - remain;
        case (off)
          32'd0: fmt_code[7:0] = b;
          32'd1: fmt_code[15:8] = b;
          32'd2: chans[7:0] = b;
          32'd3: chans[15:8] = b;
          32'd4, 32'd5, 32'd6, 32'd7: rate_seen[8*off[1:0] +: 8] = b;
          32'd14: bits[7:0] = b;
          32'd15: bits[15:8] = b;
          default: ;
        endcase
        remain = remain - 1;
        if (remain == 0) close_body();
      end
      WALK_SKIP: begin
        remain = remain - 1;
        if (remain == 0) close_body();
      end
      WALK_DATA: begin
        w.kind = 1'b0;
        w.pay = b;
        w.st = ST_OK;
        w.rate = '0;
        w.chan = '0;
        w.last = 1'b0;
        extracted_words.push_back(w);
        remain = remain - 1;
        if (remain == 0) walk = WALK_DONE;
      end
      default: ;
    endcase
    if (pos != 32'hFFFF_FFFF) pos = pos + 1;
    if (eof) begin
      s = verdict;
      if (s == ST_OK && walk != WALK_DONE) begin
        if (walk == WALK_MAGIC) s = ST_TOO_SMALL;
        else s = ST_NO_DATA;
      end
      extracted_words.push_back(report_word(s, rate_seen, chans));
      clear_parser();
    end
  endtask

  task automatic take_word(input file_word_t fw);
    int n0;
    n0 = extracted_words.size();
    parse_wav_byte(fw.b, fw.len, fw.eof);
    if (fw.typed) begin
      while (extracted_words.size() > n0) void'(extracted_words.pop_back());
      extracted_words.push_back(report_word(status_e'(fw.st), 32'd0, 16'd0));
    end
  endtask

  task automatic check_word();
    out_word_t got;
    out_word_t want;
    got = {kind_o, payload_byte_o, status_o, sample_rate_o, channel_count_o, is_last_o};
    if (extracted_words.size() == 0) begin
      bad_words++;
      if (bad_words <= MAX_REPORTS)
        $display("%0t: unexpected word, expected none, got kind %0d byte %h status %0d",
                 $time, got.kind, got.pay, got.st);
    end else begin
      want = extracted_words.pop_front();
      if (got !== want) begin
        bad_words++;
        if (bad_words <= MAX_REPORTS)
          $display({"%0t: expected kind %0d byte %h status %0d rate %h chan %h last %0d,",
                    " got kind %0d byte %h status %0d rate %h chan %h last %0d"},
                   $time, want.kind, want.pay, want.st, want.rate, want.chan, want.last,
                   got.kind, got.pay, got.st, got.rate, got.chan, got.last);
      end
    end
  endtask

  task automatic put8(input logic [7:0] v);
    file_bytes.push_back(v);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  task automatic put_fmt(input int unsigned size, input logic [15:0] code,
                         input logic [15:0] nbits);
    logic [15:0] ch;
    logic [31:0] rt;
    logic [7:0]  v;
    ch = 16'($urandom_range(0, 65535));
    rt = $urandom();
    put32(IdFmt);
    put32(size);
    for (int k = 0; k < size; k++) begin
      case (k)
        0: v = code[7:0];
        1: v = code[15:8];
        2: v = ch[7:0];
        3: v = ch[15:8];
        4, 5, 6, 7: v = rt[8*(k-4) +: 8];
        14: v = nbits[7:0];
        15: v = nbits[15:8];
        default: v = 8'($urandom_range(0, 255));
      endcase
      put8(v);
    end
    if (size[0]) put8(8'($urandom_range(0, 255)));
  endtask

  task automatic put_junk(input logic huge);
    logic [31:0] id;
    logic [31:0] n;
    id = $urandom();
    if (id == IdFmt || id == IdData) id = ~id;
    if (huge) n = $urandom() | 32'h8000_0000;
    else if ($urandom_range(0, 2) == 0) n = 0;
    else n = $urandom_range(1, 9);
    put32(id);
    put32(n);
    if (!huge) begin
      repeat (n) put8(8'($urandom_range(0, 255)));
      if (n[0]) put8(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_data(input int unsigned n);
    put32(IdData);
    put32(n);
    repeat (n) put8(8'($urandom_range(0, 255)));
  endtask

  task automatic add_file();
    int          pick;
    int          damage;
    int          k;
    logic [31:0] flen;
    logic        per_byte;
    logic [15:0] code;
    logic [15:0] nb;
    logic [7:0]  mask;
    file_word_t  fw;
    file_bytes.delete();
    per_byte = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick >= 94) begin
      if ($urandom_range(0, 1) == 0) put32(RIFF_WORD);
      repeat ($urandom_range(1, 60)) put8(8'($urandom_range(0, 255)));
      flen = ($urandom_range(0, 1) == 0) ? $urandom() : file_bytes.size();
      per_byte = ($urandom_range(0, 3) == 0);
    end else begin
      put32(RIFF_WORD);
      put32($urandom());
      put32(WAVE_WORD);
      if ($urandom_range(0, 3) == 0) put_junk(1'b0);
      if (pick >= 80 && pick < 87) begin
        put_fmt($urandom_range(0, 15), PCM_TAG, PCM_BITS);
      end else begin
        code = PCM_TAG;
        nb = PCM_BITS;
        if (pick >= 70 && pick < 80) begin
          if ($urandom_range(0, 1) == 0) begin
            code = 16'($urandom_range(0, 65535));
            if (code == PCM_TAG) code = 16'd3;
          end else begin
            nb = 16'($urandom_range(0, 65535));
            if (nb == PCM_BITS) nb = 16'd8;
          end
        end
        if ($urandom_range(0, 7) == 0)
          put_fmt(16, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        put_fmt(($urandom_range(0, 3) == 0) ? $urandom_range(16, 21) : 16, code, nb);
      end
      if ($urandom_range(0, 3) == 0) put_junk(1'b0);
      if (pick >= 87 && pick < 94) begin
        case ($urandom_range(0, 2))
          0: put_data(0);
          1: put_junk(1'b1);
          default: put_junk(1'b0);
        endcase
      end else begin
        put_data(($urandom_range(0, 5) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24));
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6)) put8(8'($urandom_range(0, 255)));
      flen = file_bytes.size();
      damage = $urandom_range(0, 15);
      case (damage)
        0: begin
          k = $urandom_range(0, 11);
          mask = 8'h01 << $urandom_range(0, 7);
          file_bytes[k] = file_bytes[k] ^ mask;
        end
        1: flen = $urandom_range(0, 43);
        2: flen = flen - $urandom_range(1, 24);
        3: flen = flen + ($urandom() >> $urandom_range(0, 31));
        4: begin
          k = $urandom_range(1, file_bytes.size() - 1);
          while (file_bytes.size() > k) void'(file_bytes.pop_back());
        end
        default: ;
      endcase
    end
    for (int i = 0; i < file_bytes.size(); i++) begin
      fw.b = file_bytes[i];
      fw.len = per_byte ? $urandom() : flen;
      fw.eof = (i == file_bytes.size() - 1);
      fw.typed = 1'b0;
      fw.st = ST_OK;
      wav_stream.push_back(fw);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (odds_timer == 0) begin
        odds_timer = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 4;
          default: idle_odds = 10;
        endcase
      end else begin
        odds_timer--;
      end
      if (push && shown == taken_bytes) begin
      end else if (push_hold != 0) begin
        push_hold--;
        push <= 1'b0;
      end else if (taken_bytes < wav_stream.size()) begin
        if (taken_bytes < quiet_from && idle_odds != 0 &&
            $urandom_range(1, idle_odds) == 1) begin
          push_hold = $urandom_range(0, 8);
          push <= 1'b0;
        end else begin
          push <= 1'b1;
          file_byte_i <= wav_stream[taken_bytes].b;
          file_length_i <= wav_stream[taken_bytes].len;
          end_of_file_i <= wav_stream[taken_bytes].eof;
          shown = taken_bytes;
        end
      end else begin
        push <= 1'b0;
      end
      if (pop_hold != 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (taken_bytes < quiet_from && idle_odds != 0 &&
                   $urandom_range(1, idle_odds) == 1) begin
        pop_hold = $urandom_range(0, 8);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (pop && !empty) begin
        moved = 1'b1;
        check_word();
      end
      if (push && !full) begin
        moved = 1'b1;
        take_word(wav_stream[taken_bytes]);
        taken_bytes++;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clear_parser();
    for (int k = 0; k < DIR_N; k++) wav_stream.push_back(dir_rows[k]);
    while (wav_stream.size() < DIR_N + ITEM_GOAL) add_file();
    quiet_from = wav_stream.size() - QUIET_TAIL;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (taken_bytes < wav_stream.size() || extracted_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (bad_words == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/wpe_pkg.sv
hw/rtl/wpe_parser.sv
hw/rtl/wpe_queue.sv
hw/rtl/wpe_emitter.sv
hw/rtl/wav_pcm16_payload_extractor.sv
bench/tb.sv
